// File: hdl/ipcf_pkg.sv
package ipcf_pkg;

    // Protocol numbers and size limits used by the classifier.
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [15:0] MIN_HDR_BYTES    = 16'd20;
    localparam logic [15:0] TCP_HDR_BYTES    = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES    = 16'd8;
    localparam logic [3:0]  IP_VERSION       = 4'd4;
    localparam logic [3:0]  MIN_IHL          = 4'd5;
    localparam logic [15:0] CNT_MAX          = 16'hFFFF;
    localparam logic [15:0] UDP_CK_ALL_ONES  = 16'hFFFF;

    // Header byte offsets with special meaning.
    localparam logic [15:0] OFS_TLEN_HI      = 16'd2;
    localparam logic [15:0] OFS_TLEN_LO      = 16'd3;
    localparam logic [15:0] OFS_PROTO        = 16'd9;
    localparam logic [15:0] OFS_IPCK_HI      = 16'd10;
    localparam logic [15:0] OFS_IPCK_LO      = 16'd11;
    localparam logic [15:0] OFS_ADDR_FIRST   = 16'd12;
    localparam logic [15:0] OFS_ADDR_END     = 16'd20;

    // L4 checksum field offsets inside the L4 header.
    localparam logic [15:0] TCP_CK_HI        = 16'd16;
    localparam logic [15:0] TCP_CK_LO        = 16'd17;
    localparam logic [15:0] UDP_CK_HI        = 16'd6;
    localparam logic [15:0] UDP_CK_LO        = 16'd7;

    // Packet status codes.
    typedef enum logic [3:0] {
        ST_IP_ONLY   = 4'd0,
        ST_TCP       = 4'd1,
        ST_UDP       = 4'd2,
        ST_L4_SHORT  = 4'd3,
        ST_TRUNC     = 4'd4,
        ST_NOT_IPV4  = 4'd5,
        ST_BAD_IHL   = 4'd6,
        ST_BAD_TLEN  = 4'd7,
        ST_HW        = 4'd8
    } status_t;

    // Per-packet summary handed from the front end to the back end.
    typedef struct packed {
        status_t      status;
        logic [23:0]  hdr_sum;
        logic [31:0]  pay_sum;
        logic [15:0]  l4_len;
    } rec_t;

endpackage

// File: hdl/ipv4_checksum_fixer.sv
// Channel    Direction  Handshake            Payload
// input      in         push / full          data_byte, last_byte, offload_pending
// result     out        empty / pop          status, ip_checksum, l4_checksum
// config     in         cfg_valid / cfg_ready cfg_data (force_software)
//
// One packet byte is taken per cycle while full is low; it adds into the header sum,
// the payload sum, both or neither. A packet's result then passes the summary queue,
// the first fold stage and the output stage, each registered, while the result side is free.
// Reset is asynchronous and clears all counters and valid bits at once, with no clearing pass.
// full rises only when QUEUE_DEPTH summaries fill the queue behind two held results,
// and then every byte waits until the result side takes a word.
module ipv4_checksum_fixer
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [7:0]   data_byte,
    input  logic         last_byte,
    input  logic         offload_pending,
    output logic         empty,
    input  logic         pop,
    output logic [3:0]   status,
    output logic [15:0]  ip_checksum,
    output logic [15:0]  l4_checksum,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    logic            accept;
    logic            rec_push;
    ipcf_pkg::rec_t  rec_in;
    ipcf_pkg::rec_t  rec_out;
    logic            q_full;
    logic            q_empty;
    logic            q_pop;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign cfg_ready = 1'b1;

    // Front end: byte accumulation and packet classification.
    ipcf_front u_front
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .data_byte       (data_byte),
        .last_byte       (last_byte),
        .offload_pending (offload_pending),
        .cfg_we          (cfg_valid),
        .cfg_data        (cfg_data),
        .rec_push        (rec_push),
        .rec             (rec_in)
    );

    // Summary queue between the two halves.
    ipcf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rec_push),
        .wr_data (rec_in),
        .rd      (q_pop),
        .rd_data (rec_out),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // Back end: checksum folding and result register.
    ipcf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_rec       (rec_out),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .status      (status),
        .ip_checksum (ip_checksum),
        .l4_checksum (l4_checksum)
    );

endmodule

// File: hdl/ipcf_front.sv
module ipcf_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    input  logic              offload_pending,
    input  logic              cfg_we,
    input  logic              cfg_data,
    output logic              rec_push,
    output ipcf_pkg::rec_t    rec
);

    logic        force_reg;
    logic [15:0] cnt_reg;
    logic [7:0]  hi_reg;
    logic [23:0] hsum_reg;
    logic [31:0] psum_reg;
    logic [3:0]  ihl_reg;
    logic [3:0]  ver_reg;
    logic [15:0] tlen_reg;
    logic [7:0]  proto_reg;
    logic        offl_reg;

    logic        first;
    logic [3:0]  ihl_c;
    logic [3:0]  ver_c;
    logic        offl_c;
    logic [7:0]  hi_c;
    logic [15:0] tlen_c;
    logic [7:0]  proto_c;
    logic [15:0] hdr16;
    logic [15:0] part;
    logic        not_sat;
    logic        in_hdr;
    logic        in_l4;
    logic [15:0] off;
    logic        is_ck;
    logic        add_hdr;
    logic        add_pay;
    logic [15:0] cnt_c;
    logic [23:0] hsum_c;
    logic [31:0] psum_c;
    logic [15:0] l4_len;
    ipcf_pkg::status_t st;

    // Header fields as seen after this byte.
    always_comb
    begin
        first   = (cnt_reg == 16'd0);
        ihl_c   = first ? data_byte[3:0] : ihl_reg;
        ver_c   = first ? data_byte[7:4] : ver_reg;
        offl_c  = first ? offload_pending : offl_reg;
        hi_c    = (cnt_reg == ipcf_pkg::OFS_TLEN_HI) ? data_byte : hi_reg;
        tlen_c  = (cnt_reg == ipcf_pkg::OFS_TLEN_LO) ? {hi_reg, data_byte} : tlen_reg;
        proto_c = (cnt_reg == ipcf_pkg::OFS_PROTO) ? data_byte : proto_reg;
        hdr16   = {10'd0, ihl_c, 2'b00};
    end

    // Decide where this byte goes in the two running sums.
    always_comb
    begin
        part    = cnt_reg[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
        not_sat = (cnt_reg != ipcf_pkg::CNT_MAX);
        in_hdr  = (cnt_reg < hdr16);
        in_l4   = !in_hdr && (cnt_reg < tlen_c);
        off     = cnt_reg - hdr16;
        is_ck   = ((proto_c == ipcf_pkg::PROTO_TCP) &&
                   ((off == ipcf_pkg::TCP_CK_HI) || (off == ipcf_pkg::TCP_CK_LO))) ||
                  ((proto_c == ipcf_pkg::PROTO_UDP) &&
                   ((off == ipcf_pkg::UDP_CK_HI) || (off == ipcf_pkg::UDP_CK_LO)));
        add_hdr = not_sat && in_hdr &&
                  (cnt_reg != ipcf_pkg::OFS_IPCK_HI) && (cnt_reg != ipcf_pkg::OFS_IPCK_LO);
        add_pay = not_sat &&
                  ((in_hdr && (cnt_reg >= ipcf_pkg::OFS_ADDR_FIRST) &&
                    (cnt_reg < ipcf_pkg::OFS_ADDR_END)) ||
                   (in_l4 && !is_ck));
        cnt_c   = not_sat ? (cnt_reg + 16'd1) : cnt_reg;
        hsum_c  = add_hdr ? (hsum_reg + {8'd0, part}) : hsum_reg;
        psum_c  = add_pay ? (psum_reg + {16'd0, part}) : psum_reg;
        l4_len  = tlen_c - hdr16;
    end

    // Classify the packet on its last byte; checks are taken in order.
    always_comb
    begin
        priority if (cnt_c < ipcf_pkg::MIN_HDR_BYTES)
            st = ipcf_pkg::ST_TRUNC;
        else if (ver_c != ipcf_pkg::IP_VERSION)
            st = ipcf_pkg::ST_NOT_IPV4;
        else if (ihl_c < ipcf_pkg::MIN_IHL)
            st = ipcf_pkg::ST_BAD_IHL;
        else if (cnt_c < hdr16)
            st = ipcf_pkg::ST_TRUNC;
        else if (tlen_c < hdr16)
            st = ipcf_pkg::ST_BAD_TLEN;
        else if (cnt_c < tlen_c)
            st = ipcf_pkg::ST_TRUNC;
        else if (!force_reg && offl_c)
            st = ipcf_pkg::ST_HW;
        else if (proto_c == ipcf_pkg::PROTO_TCP)
            st = (l4_len < ipcf_pkg::TCP_HDR_BYTES) ? ipcf_pkg::ST_L4_SHORT : ipcf_pkg::ST_TCP;
        else if (proto_c == ipcf_pkg::PROTO_UDP)
            st = (l4_len < ipcf_pkg::UDP_HDR_BYTES) ? ipcf_pkg::ST_L4_SHORT : ipcf_pkg::ST_UDP;
        else
            st = ipcf_pkg::ST_IP_ONLY;
    end

    // The summary word for the back end.
    assign rec_push    = accept && last_byte;
    assign rec.status  = st;
    assign rec.hdr_sum = hsum_c;
    assign rec.pay_sum = psum_c;
    assign rec.l4_len  = l4_len;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            force_reg <= 1'b0;
        else if (cfg_we)
            force_reg <= cfg_data;
    end

    // Per-packet state, cleared after the last byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            hi_reg    <= '0;
            hsum_reg  <= '0;
            psum_reg  <= '0;
            ihl_reg   <= '0;
            ver_reg   <= '0;
            tlen_reg  <= '0;
            proto_reg <= '0;
            offl_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                cnt_reg   <= '0;
                hi_reg    <= '0;
                hsum_reg  <= '0;
                psum_reg  <= '0;
                ihl_reg   <= '0;
                ver_reg   <= '0;
                tlen_reg  <= '0;
                proto_reg <= '0;
                offl_reg  <= 1'b0;
            end
            else
            begin
                cnt_reg   <= cnt_c;
                hi_reg    <= hi_c;
                hsum_reg  <= hsum_c;
                psum_reg  <= psum_c;
                ihl_reg   <= ihl_c;
                ver_reg   <= ver_c;
                tlen_reg  <= tlen_c;
                proto_reg <= proto_c;
                offl_reg  <= offl_c;
            end
        end
    end

endmodule

// File: hdl/ipcf_queue.sv
module ipcf_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  ipcf_pkg::rec_t    wr_data,
    input  logic              rd,
    output ipcf_pkg::rec_t    rd_data,
    output logic              q_full,
    output logic              q_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    ipcf_pkg::rec_t  slot_reg [DEPTH];
    logic [AW-1:0]   wp_reg;
    logic [AW-1:0]   rp_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_wr;
    logic            do_rd;

    assign q_full  = (cnt_reg == FULL_CNT);
    assign q_empty = (cnt_reg == '0);
    assign do_wr   = wr && !q_full;
    assign do_rd   = rd && !q_empty;
    assign rd_data = slot_reg[rp_reg];

    // Storage slots.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wp_reg] <= wr_data;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == LAST_PTR) ? '0 : wp_reg + AW'(1);
            if (do_rd)
                rp_reg <= (rp_reg == LAST_PTR) ? '0 : rp_reg + AW'(1);
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + CW'(1);
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - CW'(1);
        end
    end

endmodule

// File: hdl/ipcf_back.sv
module ipcf_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_empty,
    input  ipcf_pkg::rec_t    q_rec,
    output logic              q_pop,
    input  logic              pop,
    output logic              empty,
    output logic [3:0]        status,
    output logic [15:0]       ip_checksum,
    output logic [15:0]       l4_checksum
);

    logic                s1_v_reg;
    ipcf_pkg::status_t   s1_st_reg;
    logic [16:0]         s1_h_reg;
    logic [31:0]         s1_p_reg;
    logic                o_v_reg;
    ipcf_pkg::status_t   o_st_reg;
    logic [15:0]         o_ip_reg;
    logic [15:0]         o_l4_reg;

    logic                o_take;
    logic                s1_load;
    logic [31:0]         pseudo;
    logic [16:0]         h1;
    logic [16:0]         p1;
    logic [15:0]         p2;
    logic [15:0]         h2;
    logic [15:0]         l4_raw;
    logic [15:0]         ip_c;
    logic [15:0]         l4_c;

    // Pipeline flow: a stage moves when the one after it can take its word.
    assign o_take  = !o_v_reg || pop;
    assign s1_load = !s1_v_reg || o_take;
    assign q_pop   = s1_load && !q_empty;

    // First stage: pseudo header constants and first header fold.
    always_comb
    begin
        unique case (q_rec.status)
            ipcf_pkg::ST_TCP: pseudo = q_rec.pay_sum + {16'd0, q_rec.l4_len}
                                       + {24'd0, ipcf_pkg::PROTO_TCP};
            ipcf_pkg::ST_UDP: pseudo = q_rec.pay_sum + {16'd0, q_rec.l4_len}
                                       + {24'd0, ipcf_pkg::PROTO_UDP};
            default:          pseudo = q_rec.pay_sum;
        endcase
        h1 = {1'b0, q_rec.hdr_sum[15:0]} + {9'd0, q_rec.hdr_sum[23:16]};
    end

    // Second stage: finish the folds, invert, send a UDP checksum of zero as all ones, and zero what is not valid.
    always_comb
    begin
        p1     = {1'b0, s1_p_reg[15:0]} + {1'b0, s1_p_reg[31:16]};
        p2     = p1[15:0] + {15'd0, p1[16]};
        h2     = s1_h_reg[15:0] + {15'd0, s1_h_reg[16]};
        l4_raw = ~p2;
        unique case (s1_st_reg)
            ipcf_pkg::ST_TCP:
            begin
                ip_c = ~h2;
                l4_c = l4_raw;
            end
            ipcf_pkg::ST_UDP:
            begin
                ip_c = ~h2;
                l4_c = (l4_raw == 16'd0) ? ipcf_pkg::UDP_CK_ALL_ONES : l4_raw;
            end
            ipcf_pkg::ST_IP_ONLY, ipcf_pkg::ST_L4_SHORT:
            begin
                ip_c = ~h2;
                l4_c = 16'd0;
            end
            default:
            begin
                ip_c = 16'd0;
                l4_c = 16'd0;
            end
        endcase
    end

    // Stage data registers.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_st_reg <= q_rec.status;
            s1_h_reg  <= h1;
            s1_p_reg  <= pseudo;
        end
        if (o_take)
        begin
            o_st_reg <= s1_st_reg;
            o_ip_reg <= ip_c;
            o_l4_reg <= l4_c;
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            o_v_reg  <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_v_reg <= !q_empty;
            if (o_take)
                o_v_reg <= s1_v_reg;
        end
    end

    assign empty       = !o_v_reg;
    assign status      = o_st_reg;
    assign ip_checksum = o_ip_reg;
    assign l4_checksum = o_l4_reg;

endmodule

// File: hdl/ipcf_checker.sv
module ipcf_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         empty,
    input  logic         pop,
    input  logic [3:0]   status,
    input  logic [15:0]  ip_checksum,
    input  logic [15:0]  l4_checksum
);

    // A waiting result carries a defined status code.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status <= ipcf_pkg::ST_HW))
        else $error("result status out of range");

    // Rejected packets and packets left to hardware offload carry no checksums.
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status >= ipcf_pkg::ST_TRUNC))
        |-> (ip_checksum == 16'd0 && l4_checksum == 16'd0))
        else $error("checksum given for a rejected packet");

    // Only TCP and UDP results carry an L4 checksum.
    a_l4_only_tcp_udp: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ipcf_pkg::ST_TCP && status != ipcf_pkg::ST_UDP)
        |-> (l4_checksum == 16'd0))
        else $error("L4 checksum given for a packet without one");

    // A UDP checksum of zero is always sent as all ones.
    a_udp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ipcf_pkg::ST_UDP) |-> (l4_checksum != 16'd0))
        else $error("UDP checksum of zero");

    // A result that is not taken stays on the ports unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(status) && $stable(ip_checksum)
                              && $stable(l4_checksum)))
        else $error("waiting result changed");

endmodule

bind ipv4_checksum_fixer ipcf_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .status      (status),
    .ip_checksum (ip_checksum),
    .l4_checksum (l4_checksum)
);
